@@ rtl/psc_pkg.sv @@
// ----------------------------------------------------------------------------
// psc_pkg
// Shared types and constants for the page sharing conflict filter.
// ----------------------------------------------------------------------------
package psc_pkg;

    // Field widths fixed by the interface
    localparam int TID_W  = 3;
    localparam int ADDR_W = 64;
    localparam int REQ_W  = 2;
    localparam int CFG_W  = 4;

    // Defaults for the top-level parameters
    localparam int THREADS_DEF         = 8;
    localparam int PAGE_INDEX_BITS_DEF = 20;
    localparam int PAGE_SHIFT_DEF      = 12;

    // Entries in the queue between the front and the back
    localparam int QUEUE_DEPTH_DEF = 2;

    // Reset value of the active thread count register
    localparam logic [CFG_W-1:0] ACTIVE_THREADS_RESET = 4'd8;

    // Request kinds
    typedef enum logic [REQ_W-1:0] {
        REQ_REC_LOAD    = 2'd0,
        REQ_REC_STORE   = 2'd1,
        REQ_MATCH_LOAD  = 2'd2,
        REQ_MATCH_STORE = 2'd3
    } req_type_t;

endpackage

@@ rtl/page_sharing_conflict_filter.sv @@
// ----------------------------------------------------------------------------
// page_sharing_conflict_filter
// Per-thread page access filter reporting cross-thread page conflicts.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_*: one memory access per item (kind, thread, address).
//   Records set the thread's loaded or stored bit for the page and give no
//   result. Matches give one result item per conflicting thread and kind on
//   m_*, ascending thread order, loaded before stored, last one marked.
//   cfg_* writes the active thread count; write it only while idle.
// Throughput: the front takes a new item only once the single read-modify-write
//   of the page table RAM for the last one (read, then write or queue) ends.
//   The back emits one result per cycle while the output is not stalled, and
//   loads a match's mask before its first result.
// Path: an accepted match is read from the page table RAM, pushed into the
//   queue, loaded into the back's mask and emitted from the output register.
// Reset: the page table is swept to zero, one row per cycle, over all
//   2**PAGE_INDEX_BITS rows (1048576 by default); s_ready stays low until
//   the sweep ends. Configuration writes are taken during the sweep.
// Stall: results wait in the output register and a 2-entry queue; when
//   the queue is full the front holds its match and stops accepting.
// ----------------------------------------------------------------------------
module page_sharing_conflict_filter #(
    parameter int THREADS         = psc_pkg::THREADS_DEF,
    parameter int PAGE_INDEX_BITS = psc_pkg::PAGE_INDEX_BITS_DEF,
    parameter int PAGE_SHIFT      = psc_pkg::PAGE_SHIFT_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // configuration
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [psc_pkg::CFG_W-1:0]   cfg_active_threads,
    // access input
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [psc_pkg::REQ_W-1:0]   s_req_type,
    input  logic [psc_pkg::TID_W-1:0]   s_thread_id,
    input  logic [psc_pkg::ADDR_W-1:0]  s_access_address,
    // conflict output
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [psc_pkg::TID_W-1:0]   m_requester_thread,
    output logic [psc_pkg::ADDR_W-1:0]  m_echoed_address,
    output logic [psc_pkg::TID_W-1:0]   m_other_thread,
    output logic                        m_conflict_kind,
    output logic                        m_last_of_run
);
    import psc_pkg::*;

    localparam int ROW_W = 2 * THREADS;
    localparam int Q_W   = TID_W + ADDR_W + ROW_W;

    logic [CFG_W-1:0] active_threads_reg;
    logic             q_push;
    logic [Q_W-1:0]   q_push_data;
    logic             q_full;
    logic             q_valid;
    logic             q_ready;
    logic [Q_W-1:0]   q_data;

    // Configuration register, always writable
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_threads_reg <= ACTIVE_THREADS_RESET;
        end else if (cfg_valid) begin
            active_threads_reg <= cfg_active_threads;
        end
    end

    psc_front #(
        .THREADS         (THREADS),
        .PAGE_INDEX_BITS (PAGE_INDEX_BITS),
        .PAGE_SHIFT      (PAGE_SHIFT)
    ) u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_req_type       (s_req_type),
        .s_thread_id      (s_thread_id),
        .s_access_address (s_access_address),
        .active_threads   (active_threads_reg),
        .push             (q_push),
        .push_data        (q_push_data),
        .q_full           (q_full)
    );

    psc_queue #(
        .WIDTH (Q_W),
        .DEPTH (QUEUE_DEPTH_DEF)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_data  (q_data)
    );

    psc_back #(
        .THREADS (THREADS)
    ) u_back (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .q_valid            (q_valid),
        .q_ready            (q_ready),
        .q_data             (q_data),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_requester_thread (m_requester_thread),
        .m_echoed_address   (m_echoed_address),
        .m_other_thread     (m_other_thread),
        .m_conflict_kind    (m_conflict_kind),
        .m_last_of_run      (m_last_of_run)
    );

    // Never push into a full queue
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> !q_full)
        else $error("push into full queue");

    // The requester is never reported as its own conflict
    a_other_thread: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_other_thread != m_requester_thread))
        else $error("requester reported as conflicting thread");

    // One table update per item: no accept right after an accept
    a_two_cycle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("back-to-back accept");

    // A pushed match always carries at least one conflict
    a_push_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> (q_push_data[ROW_W-1:0] != '0))
        else $error("empty conflict mask queued");

endmodule

@@ rtl/psc_ram.sv @@
// ----------------------------------------------------------------------------
// psc_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module psc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port, old data on a same-address collision
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/psc_front.sv @@
// ----------------------------------------------------------------------------
// psc_front
// Accepts accesses, clears the page table after reset, updates the table on
// records and builds the conflict mask for matches.
// ----------------------------------------------------------------------------
module psc_front #(
    parameter int THREADS         = 8,
    parameter int PAGE_INDEX_BITS = 20,
    parameter int PAGE_SHIFT      = 12,
    localparam int ROW_W          = 2 * THREADS,
    localparam int Q_W            = psc_pkg::TID_W + psc_pkg::ADDR_W + ROW_W
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [psc_pkg::REQ_W-1:0]   s_req_type,
    input  logic [psc_pkg::TID_W-1:0]   s_thread_id,
    input  logic [psc_pkg::ADDR_W-1:0]  s_access_address,
    input  logic [psc_pkg::CFG_W-1:0]   active_threads,
    output logic                        push,
    output logic [Q_W-1:0]              push_data,
    input  logic                        q_full
);
    import psc_pkg::*;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RES
    } state_t;

    localparam int ROWS = 1 << PAGE_INDEX_BITS;

    state_t                     state_reg, state_next;
    logic [PAGE_INDEX_BITS-1:0] clr_idx_reg, clr_idx_next;
    req_type_t                  req_reg;
    logic [TID_W-1:0]           tid_reg;
    logic [ADDR_W-1:0]          addr_reg;

    logic                       accept;
    logic                       ram_we;
    logic [PAGE_INDEX_BITS-1:0] ram_waddr;
    logic [ROW_W-1:0]           ram_wdata;
    logic [ROW_W-1:0]           row_bits;
    logic                       is_record;
    logic                       is_store;
    logic [ROW_W-1:0]           set_bits;
    logic [ROW_W-1:0]           conf_mask;
    logic                       res_done;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    // Page table, read once per accepted item
    psc_ram #(
        .WIDTH (ROW_W),
        .DEPTH (ROWS)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (s_access_address[PAGE_SHIFT +: PAGE_INDEX_BITS]),
        .rdata (row_bits)
    );

    assign is_record = (req_reg == REQ_REC_LOAD) || (req_reg == REQ_REC_STORE);
    assign is_store  = (req_reg == REQ_REC_STORE) || (req_reg == REQ_MATCH_STORE);

    // Build the bit to set on a record and the conflict mask on a match
    always_comb begin
        set_bits  = '0;
        conf_mask = '0;
        for (int i = 0; i < THREADS; i++) begin
            set_bits[2*i]     = (int'(tid_reg) == i) && !is_store;
            set_bits[2*i+1]   = (int'(tid_reg) == i) && is_store;
            conf_mask[2*i]    = (i < int'(active_threads)) && (int'(tid_reg) != i)
                                && is_store && row_bits[2*i];
            conf_mask[2*i+1]  = (i < int'(active_threads)) && (int'(tid_reg) != i)
                                && row_bits[2*i+1];
        end
    end

    // Share the write port between the clearing pass and record updates
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = addr_reg[PAGE_SHIFT +: PAGE_INDEX_BITS];
        ram_wdata = row_bits | set_bits;
        if (state_reg == ST_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = clr_idx_reg;
            ram_wdata = '0;
        end else if (state_reg == ST_RES && is_record) begin
            ram_we = 1'b1;
        end
    end

    // Hand a match with conflicts to the queue; drop one without any
    assign res_done  = is_record || (conf_mask == '0) || !q_full;
    assign push      = (state_reg == ST_RES) && !is_record && (conf_mask != '0) && !q_full;
    assign push_data = {tid_reg, addr_reg, conf_mask};

    // Next state
    always_comb begin
        state_next   = state_reg;
        clr_idx_next = clr_idx_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                clr_idx_next = clr_idx_reg + 1'b1;
                if (&clr_idx_reg) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_RES;
                end
            end
            ST_RES: begin
                if (res_done) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    // Hold state and the accepted item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_idx_reg <= '0;
        end else begin
            state_reg   <= state_next;
            clr_idx_reg <= clr_idx_next;
        end
        if (accept) begin
            req_reg  <= req_type_t'(s_req_type);
            tid_reg  <= s_thread_id;
            addr_reg <= s_access_address;
        end
    end

endmodule

@@ rtl/psc_queue.sv @@
// ----------------------------------------------------------------------------
// psc_queue
// Short FIFO between the front and the back.
// ----------------------------------------------------------------------------
module psc_queue #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2,
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = slot_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;

    // Advance pointers and count
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed item
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ rtl/psc_back.sv @@
// ----------------------------------------------------------------------------
// psc_back
// Walks a conflict mask lowest bit first and emits one result per set bit.
// ----------------------------------------------------------------------------
module psc_back #(
    parameter int THREADS  = 8,
    localparam int ROW_W   = 2 * THREADS,
    localparam int IDX_W   = $clog2(ROW_W),
    localparam int Q_W     = psc_pkg::TID_W + psc_pkg::ADDR_W + ROW_W
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        q_valid,
    output logic                        q_ready,
    input  logic [Q_W-1:0]              q_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [psc_pkg::TID_W-1:0]   m_requester_thread,
    output logic [psc_pkg::ADDR_W-1:0]  m_echoed_address,
    output logic [psc_pkg::TID_W-1:0]   m_other_thread,
    output logic                        m_conflict_kind,
    output logic                        m_last_of_run
);
    import psc_pkg::*;

    logic [ROW_W-1:0]  mask_reg;
    logic [TID_W-1:0]  tid_reg;
    logic [ADDR_W-1:0] addr_reg;

    logic              m_valid_reg;
    logic [TID_W-1:0]  req_tid_reg;
    logic [ADDR_W-1:0] echo_addr_reg;
    logic [TID_W-1:0]  other_reg;
    logic              kind_reg;
    logic              last_reg;

    logic [ROW_W-1:0]  low_bit;
    logic [IDX_W-1:0]  low_idx;
    logic              emit;
    logic              load;

    // Isolate the lowest pending conflict and its position
    assign low_bit = mask_reg & (~mask_reg + 1'b1);
    always_comb begin
        low_idx = '0;
        for (int j = 0; j < ROW_W; j++) begin
            if (low_bit[j]) begin
                low_idx = low_idx | IDX_W'(j);
            end
        end
    end

    assign q_ready = (mask_reg == '0);
    assign load    = q_valid && q_ready;
    assign emit    = (mask_reg != '0) && (!m_valid_reg || m_ready);

    // Take a new mask or retire the lowest bit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (load) begin
                mask_reg <= q_data[ROW_W-1:0];
            end else if (emit) begin
                mask_reg <= mask_reg & ~low_bit;
            end
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Hold the item being walked and the output payload
    always_ff @(posedge aclk) begin
        if (load) begin
            tid_reg  <= q_data[Q_W-1 -: TID_W];
            addr_reg <= q_data[ROW_W +: ADDR_W];
        end
        if (emit) begin
            req_tid_reg   <= tid_reg;
            echo_addr_reg <= addr_reg;
            other_reg     <= TID_W'(low_idx >> 1);
            kind_reg      <= low_idx[0];
            last_reg      <= ((mask_reg & ~low_bit) == '0);
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_requester_thread = req_tid_reg;
    assign m_echoed_address   = echo_addr_reg;
    assign m_other_thread     = other_reg;
    assign m_conflict_kind    = kind_reg;
    assign m_last_of_run      = last_reg;

endmodule

@@ dv/tb_page_sharing_conflict_filter.sv @@
// ----------------------------------------------------------------------------
// tb_page_sharing_conflict_filter
// Self-checking testbench for the page sharing conflict filter. A shadow
// page table in the bench predicts the conflict list of every accepted
// match, and each result item is checked field by field, in order, against
// that list. Directed accesses, scan-limit settings, a long output stall
// and random traffic over small page pools run in turn.
// ----------------------------------------------------------------------------
module tb_page_sharing_conflict_filter;

    timeunit 1ns;
    timeprecision 1ps;

    import psc_pkg::*;

    localparam int THREADS         = THREADS_DEF;
    localparam int PAGE_INDEX_BITS = PAGE_INDEX_BITS_DEF;
    localparam int PAGE_SHIFT      = PAGE_SHIFT_DEF;

    localparam int  CLK_PERIOD    = 10;
    localparam int  SETTLE_CYCLES = 12;
    localparam int  MAX_REPORTS   = 100;
    // The reset sweep alone takes one cycle per page table row
    localparam int  LIMIT_CYCLES  = 3 * (1 << PAGE_INDEX_BITS) + 400000;

    localparam logic [PAGE_INDEX_BITS-1:0] PAGE_A = 'h00123;
    localparam logic [PAGE_INDEX_BITS-1:0] PAGE_B = 'h0abcd;

    typedef struct {
        logic [TID_W-1:0]  requester;
        logic [ADDR_W-1:0] addr;
        logic [TID_W-1:0]  other;
        logic              kind;
        logic              last_flag;
    } conflict_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic              cfg_valid          = 1'b0;
    logic              cfg_ready;
    logic [CFG_W-1:0]  cfg_active_threads = '0;

    logic              s_valid          = 1'b0;
    logic              s_ready;
    logic [REQ_W-1:0]  s_req_type       = '0;
    logic [TID_W-1:0]  s_thread_id      = '0;
    logic [ADDR_W-1:0] s_access_address = '0;

    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [TID_W-1:0]  m_requester_thread;
    logic [ADDR_W-1:0] m_echoed_address;
    logic [TID_W-1:0]  m_other_thread;
    logic              m_conflict_kind;
    logic              m_last_of_run;

    // Shadow state of the block
    logic [2*THREADS-1:0] shadow_page_bits [logic [PAGE_INDEX_BITS-1:0]];
    logic [CFG_W-1:0]     active_threads_shadow = ACTIVE_THREADS_RESET;
    conflict_t            expected_conflicts [$];

    int error_count = 0;
    int cycle_count = 0;

    // Sender burst state and receiver stall state
    int   burst_left    = 0;
    int   rx_mode       = 0;
    int   rx_phase_left = 0;
    int   rx_hold_req   = 0;
    logic rx_holding    = 1'b0;

    page_sharing_conflict_filter #(
        .THREADS         (THREADS),
        .PAGE_INDEX_BITS (PAGE_INDEX_BITS),
        .PAGE_SHIFT      (PAGE_SHIFT)
    ) dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_active_threads (cfg_active_threads),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_req_type         (s_req_type),
        .s_thread_id        (s_thread_id),
        .s_access_address   (s_access_address),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_requester_thread (m_requester_thread),
        .m_echoed_address   (m_echoed_address),
        .m_other_thread     (m_other_thread),
        .m_conflict_kind    (m_conflict_kind),
        .m_last_of_run      (m_last_of_run)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // Stop a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    // Record accesses into the shadow table; list conflicts of a match
    function automatic void predict_access(input req_type_t kind,
                                           input logic [TID_W-1:0] tid,
                                           input logic [ADDR_W-1:0] addr);
        logic [PAGE_INDEX_BITS-1:0] row;
        logic [2*THREADS-1:0]       bits;
        int                         scan_limit;
        conflict_t                  pending;
        bit                         have_pending;

        row  = addr[PAGE_SHIFT +: PAGE_INDEX_BITS];
        bits = shadow_page_bits.exists(row) ? shadow_page_bits[row] : '0;
        if (kind == REQ_REC_LOAD || kind == REQ_REC_STORE) begin
            if (int'(tid) < THREADS) begin
                bits[2 * tid + ((kind == REQ_REC_STORE) ? 1 : 0)] = 1'b1;
                shadow_page_bits[row] = bits;
            end
            return;
        end

        scan_limit   = (int'(active_threads_shadow) > THREADS) ? THREADS
                                                               : int'(active_threads_shadow);
        have_pending = 1'b0;
        pending.requester = tid;
        pending.addr      = addr;
        pending.last_flag = 1'b0;
        for (int i = 0; i < scan_limit; i++) begin
            if (i == int'(tid))
                continue;
            // Hold each conflict back one step so the final one can be marked
            if (kind == REQ_MATCH_STORE && bits[2 * i]) begin
                if (have_pending)
                    expected_conflicts.push_back(pending);
                pending.other = i[TID_W-1:0];
                pending.kind  = 1'b0;
                have_pending  = 1'b1;
            end
            if (bits[2 * i + 1]) begin
                if (have_pending)
                    expected_conflicts.push_back(pending);
                pending.other = i[TID_W-1:0];
                pending.kind  = 1'b1;
                have_pending  = 1'b1;
            end
        end
        if (have_pending) begin
            pending.last_flag = 1'b1;
            expected_conflicts.push_back(pending);
        end
    endfunction

    // Offer one access, idling between bursts, and predict it on acceptance
    task automatic send_access(input req_type_t kind, input logic [TID_W-1:0] tid,
                               input logic [ADDR_W-1:0] addr);
        int gap_len;

        if (burst_left == 0) begin
            gap_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap_len > 0) begin
                s_valid <= 1'b0;
                repeat (gap_len) @(posedge aclk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                      : $urandom_range(1, 10);
        end
        s_valid          <= 1'b1;
        s_req_type       <= kind;
        s_thread_id      <= tid;
        s_access_address <= addr;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_access(kind, tid, addr);
        burst_left--;
    endtask

    // Pause the sender until every expected result is back and the block settles
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (expected_conflicts.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_active_threads(input logic [CFG_W-1:0] value);
        cfg_valid          <= 1'b1;
        cfg_active_threads <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        active_threads_shadow = value;
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [ADDR_W-1:0] address_in_page(
            input logic [PAGE_INDEX_BITS-1:0] page);
        logic [ADDR_W-1:0] addr;

        addr = {$urandom(), $urandom()};
        addr[PAGE_SHIFT +: PAGE_INDEX_BITS] = page;
        return addr;
    endfunction

    // Stall the output on a changing pattern; hold it off on request
    always @(posedge aclk) begin : rx_pattern
        logic ready_next;

        if (rx_phase_left == 0) begin
            rx_mode       = $urandom_range(0, 3);
            rx_phase_left = $urandom_range(20, 80);
        end else begin
            rx_phase_left--;
        end
        case (rx_mode)
            0: ready_next = 1'b1;
            1: ready_next = ($urandom_range(0, 1) != 0);
            2: ready_next = ($urandom_range(0, 3) == 0);
            default: ready_next = ($urandom_range(0, 4) != 0);
        endcase
        m_ready <= ready_next && !rx_holding;
    end

    // Count out a long output hold-off
    initial begin : rx_hold
        int hold_len;

        forever begin
            wait (rx_hold_req != 0);
            hold_len = rx_hold_req;
            rx_holding <= 1'b1;
            repeat (hold_len) @(posedge aclk);
            rx_holding <= 1'b0;
            rx_hold_req = 0;
        end
    end

    // Check each result item against the oldest expected conflict
    always @(posedge aclk) begin : check_results
        conflict_t want;

        if (aresetn && m_valid && m_ready) begin
            if (expected_conflicts.size() == 0) begin
                report_mismatch($sformatf("unexpected item: req %0d other %0d kind %0d",
                                          m_requester_thread, m_other_thread,
                                          m_conflict_kind));
            end else begin
                want = expected_conflicts.pop_front();
                if (m_requester_thread !== want.requester)
                    report_mismatch($sformatf("requester_thread %0d, want %0d",
                                              m_requester_thread, want.requester));
                if (m_echoed_address !== want.addr)
                    report_mismatch($sformatf("echoed_address %h, want %h",
                                              m_echoed_address, want.addr));
                if (m_other_thread !== want.other)
                    report_mismatch($sformatf("other_thread %0d, want %0d",
                                              m_other_thread, want.other));
                if (m_conflict_kind !== want.kind)
                    report_mismatch($sformatf("conflict_kind %0d, want %0d (other %0d)",
                                              m_conflict_kind, want.kind, want.other));
                if (m_last_of_run !== want.last_flag)
                    report_mismatch($sformatf("last_of_run %0d, want %0d (other %0d)",
                                              m_last_of_run, want.last_flag, want.other));
            end
        end
    end

    // Empty page, single conflicts, aliased addresses, the longest list
    task automatic test_directed();
        write_active_threads(4'd8);
        send_access(REQ_MATCH_LOAD, 3'd2, 64'h0);
        send_access(REQ_REC_LOAD, 3'd0, address_in_page(PAGE_A));
        send_access(REQ_REC_STORE, 3'd1, address_in_page(PAGE_A));
        send_access(REQ_MATCH_LOAD, 3'd0, address_in_page(PAGE_A));
        send_access(REQ_MATCH_STORE, 3'd1, address_in_page(PAGE_A));
        // Bits above the page index must not split the page
        send_access(REQ_REC_STORE, 3'd3, {ADDR_W{1'b1}});
        send_access(REQ_MATCH_LOAD, 3'd4, 64'h0000_0000_ffff_f000);
        send_access(REQ_MATCH_STORE, 3'd3, {ADDR_W{1'b1}});
        // Fill page B for every thread but 0, then match from both ends
        for (int t = 1; t < THREADS; t++) begin
            send_access(REQ_REC_LOAD, t[TID_W-1:0], address_in_page(PAGE_B));
            send_access(REQ_REC_STORE, t[TID_W-1:0], address_in_page(PAGE_B));
        end
        send_access(REQ_MATCH_STORE, 3'd0, address_in_page(PAGE_B));
        send_access(REQ_MATCH_LOAD, 3'd7, address_in_page(PAGE_B));
        wait_idle();
    endtask

    // Walk the active thread count over zero, small, clamped and full values
    task automatic test_scan_limit();
        logic [CFG_W-1:0] settings [8];

        settings = '{4'd0, 4'd1, 4'd3, 4'd15, 4'd9, 4'd5,
                     CFG_W'($urandom_range(0, 15)), 4'd8};
        foreach (settings[k]) begin
            write_active_threads(settings[k]);
            send_access(REQ_MATCH_STORE, 3'd0, address_in_page(PAGE_B));
            send_access(REQ_MATCH_STORE, TID_W'($urandom_range(0, 7)),
                        address_in_page(PAGE_B));
            send_access(REQ_MATCH_LOAD, TID_W'($urandom_range(0, 7)),
                        address_in_page(PAGE_B));
            wait_idle();
        end
    endtask

    // Hold the output off while long matches keep coming, then drain
    task automatic test_backpressure();
        rx_hold_req = 400;
        for (int n = 0; n < 24; n++)
            send_access(REQ_MATCH_STORE, TID_W'($urandom_range(0, 7)),
                        address_in_page(PAGE_B));
        wait_idle();
    endtask

    // Random traffic on a few fresh pages per segment, with some noise
    task automatic test_random();
        logic [PAGE_INDEX_BITS-1:0] pool [6];
        logic [CFG_W-1:0]           seg_cfg;
        req_type_t                  kind;
        logic [ADDR_W-1:0]          addr;

        for (int seg = 0; seg < 4; seg++) begin
            case (seg)
                0: seg_cfg = 4'd8;
                1: seg_cfg = CFG_W'($urandom_range(0, 15));
                2: seg_cfg = 4'd15;
                default: seg_cfg = CFG_W'($urandom_range(1, 7));
            endcase
            write_active_threads(seg_cfg);
            foreach (pool[p])
                pool[p] = PAGE_INDEX_BITS'($urandom());
            if (seg == 0) begin
                pool[0] = '0;
                pool[1] = '1;
            end
            for (int n = 0; n < 27; n++) begin
                if ($urandom_range(0, 9) == 0) begin
                    kind = req_type_t'($urandom_range(0, 3));
                    addr = {$urandom(), $urandom()};
                end else begin
                    if ($urandom_range(0, 99) < 55)
                        kind = ($urandom_range(0, 1) != 0) ? REQ_REC_STORE : REQ_REC_LOAD;
                    else
                        kind = ($urandom_range(0, 1) != 0) ? REQ_MATCH_STORE
                                                           : REQ_MATCH_LOAD;
                    addr = address_in_page(pool[$urandom_range(0, 5)]);
                end
                send_access(kind, TID_W'($urandom_range(0, 7)), addr);
            end
            wait_idle();
        end
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        test_directed();
        test_scan_limit();
        test_backpressure();
        test_random();

        wait_idle();
        repeat (20) @(posedge aclk);
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
